// ===== rtl/hbbc_pkg.sv =====
// Package for the hashed block buffer cache: sizes, opcodes, status codes, FSM states.
// No dependencies.
`timescale 1ns / 1ps
package hbbc_pkg;
    localparam int NumBuffers = 30;
    localparam int NumBuckets = 13;
    localparam int SlotW      = 5;
    localparam int CountW     = 8;
    localparam logic [SlotW-1:0] NullLink = 5'd31;
    localparam logic [CountW-1:0] CountMax = 8'd255;

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_RESET,
        S_IDLE,
        S_MOD,
        S_HIT_WALK,
        S_FREE_HEAD,
        S_FREE_WALK,
        S_UNLINK_WALK,
        S_CLAIM,
        S_COUNT,
        S_DONE
    } t_state;

    // Controller -> datapath commands.
    typedef struct packed {
        logic load;        // latch input word
        logic mod_step;    // one step of block mod buckets (quotient latch or subtract)
        logic init_step;   // reset sweep over chains
        logic hit_step;    // advance hit walk cursor
        logic bk_load;     // load cursor from scan bucket head
        logic free_step;   // advance free walk cursor
        logic bk_next;     // move scan to next bucket
        logic unl_start;   // start unlink walk
        logic unl_step;    // advance unlink walk
        logic claim;       // retag + move to target head
        logic hit_apply;   // apply hit
        logic count_apply; // apply release/pin/unpin
        logic fail;        // no free buffer
    } t_cmd;

    // Datapath -> controller status.
    typedef struct packed {
        logic init_done;
        logic mod_done;
        logic is_get;
        logic cur_null;
        logic cur_match;
        logic cur_free;
        logic walk_over;
        logic scan_over;
        logic same_bucket;
        logic unl_done;
    } t_stat;
endpackage

// ===== rtl/hbbc_if.sv =====
// Valid/ready channel interface carrying a payload word.
// Depends on nothing.
`timescale 1ns / 1ps
interface hbbc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  device;
    logic [15:0] block_number;
    logic [4:0]  buffer_slot;
    modport source (output valid, opcode, device, block_number, buffer_slot, input ready);
    modport sink   (input valid, opcode, device, block_number, buffer_slot, output ready);
endinterface

interface hbbc_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] granted_slot;
    logic       was_hit;
    logic       needs_read;
    logic [1:0] status;
    modport source (output valid, granted_slot, was_hit, needs_read, status, input ready);
    modport sink   (input valid, granted_slot, was_hit, needs_read, status, output ready);
endinterface

// ===== rtl/hbbc_ctrl.sv =====
// Controller FSM for the buffer cache: sequences walks and updates.
// Depends on hbbc_pkg.
`timescale 1ns / 1ps
module hbbc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_busy,
    output logic             o_out_set,
    input  hbbc_pkg::t_stat  i_stat,
    output hbbc_pkg::t_cmd   o_cmd
);
    hbbc_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= hbbc_pkg::S_RESET;
        else          r_state <= n_state;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hbbc_pkg::S_RESET: if (i_stat.init_done) n_state = hbbc_pkg::S_IDLE;
            hbbc_pkg::S_IDLE: if (i_in_valid) n_state = hbbc_pkg::S_MOD;
            hbbc_pkg::S_MOD: begin
                if (i_stat.mod_done)
                    n_state = i_stat.is_get ? hbbc_pkg::S_HIT_WALK : hbbc_pkg::S_COUNT;
            end
            hbbc_pkg::S_HIT_WALK: begin
                if (i_stat.cur_null || i_stat.walk_over) n_state = hbbc_pkg::S_FREE_HEAD;
                else if (i_stat.cur_match) n_state = hbbc_pkg::S_DONE;
            end
            hbbc_pkg::S_FREE_HEAD: n_state = hbbc_pkg::S_FREE_WALK;
            hbbc_pkg::S_FREE_WALK: begin
                if (i_stat.cur_null || i_stat.walk_over) begin
                    if (i_stat.scan_over) n_state = hbbc_pkg::S_DONE;
                    else                  n_state = hbbc_pkg::S_FREE_HEAD;
                end else if (i_stat.cur_free) begin
                    n_state = i_stat.same_bucket ? hbbc_pkg::S_CLAIM
                                                 : hbbc_pkg::S_UNLINK_WALK;
                end
            end
            hbbc_pkg::S_UNLINK_WALK: if (i_stat.unl_done) n_state = hbbc_pkg::S_CLAIM;
            hbbc_pkg::S_CLAIM: n_state = hbbc_pkg::S_DONE;
            hbbc_pkg::S_COUNT: n_state = hbbc_pkg::S_DONE;
            hbbc_pkg::S_DONE:  if (!i_out_busy) n_state = hbbc_pkg::S_IDLE;
            default: n_state = hbbc_pkg::S_RESET;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_set = 1'b0;
        case (r_state)
            hbbc_pkg::S_RESET: o_cmd.init_step = 1'b1;
            hbbc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            hbbc_pkg::S_MOD: o_cmd.mod_step = 1'b1;
            hbbc_pkg::S_HIT_WALK: begin
                if (!(i_stat.cur_null || i_stat.walk_over)) begin
                    if (i_stat.cur_match) o_cmd.hit_apply = 1'b1;
                    else                  o_cmd.hit_step = 1'b1;
                end
            end
            hbbc_pkg::S_FREE_HEAD: o_cmd.bk_load = 1'b1;
            hbbc_pkg::S_FREE_WALK: begin
                if (i_stat.cur_null || i_stat.walk_over) begin
                    if (i_stat.scan_over) o_cmd.fail = 1'b1;
                    else                  o_cmd.bk_next = 1'b1;
                end else if (i_stat.cur_free) begin
                    if (!i_stat.same_bucket) o_cmd.unl_start = 1'b1;
                end else begin
                    o_cmd.free_step = 1'b1;
                end
            end
            hbbc_pkg::S_UNLINK_WALK: o_cmd.unl_step = 1'b1;
            hbbc_pkg::S_CLAIM: o_cmd.claim = 1'b1;
            hbbc_pkg::S_COUNT: o_cmd.count_apply = 1'b1;
            hbbc_pkg::S_DONE: o_out_set = !i_out_busy;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == hbbc_pkg::S_IDLE) else $error("ready outside idle");
    a_one_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.hit_step, o_cmd.free_step, o_cmd.unl_step, o_cmd.claim}))
        else $error("conflicting walk commands");
    a_set_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_set |-> !i_out_busy) else $error("result overwrite");
`endif
endmodule

// ===== rtl/hbbc_dp.sv =====
// Datapath for the buffer cache: tag/count/link registers, walk cursors, result word.
// Depends on hbbc_pkg.
`timescale 1ns / 1ps
module hbbc_dp #(
    parameter int NUM_BUFFERS = hbbc_pkg::NumBuffers,
    parameter int NUM_BUCKETS = hbbc_pkg::NumBuckets
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hbbc_pkg::t_cmd  i_cmd,
    output hbbc_pkg::t_stat o_stat,
    input  logic [1:0]      i_opcode,
    input  logic [7:0]      i_device,
    input  logic [15:0]     i_block_number,
    input  logic [4:0]      i_buffer_slot,
    output logic [4:0]      o_granted_slot,
    output logic            o_was_hit,
    output logic            o_needs_read,
    output logic [1:0]      o_status
);
    localparam int BkW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int StepW = $clog2(NUM_BUFFERS + 1);
    localparam logic [4:0] LastSlot = 5'(NUM_BUFFERS - 1);
    localparam logic [15:0] BkDiv = 16'(NUM_BUCKETS);
    localparam int NumInit = NUM_BUFFERS + NUM_BUCKETS;
    localparam int InitW = $clog2(NumInit + 1);
    localparam logic [BkW-1:0] BkLast = BkW'(NUM_BUCKETS - 1);
    // reciprocal of the bucket count, scaled by 2^24; exact for 16-bit blocks
    localparam logic [24:0] ModMul = 25'(((2 ** 24) + NUM_BUCKETS - 1) / NUM_BUCKETS);

    // Per-buffer state
    logic [7:0]  r_tag_dev  [NUM_BUFFERS];
    logic [15:0] r_tag_blk  [NUM_BUFFERS];
    logic [7:0]  r_count    [NUM_BUFFERS];
    logic        r_cvalid   [NUM_BUFFERS];
    logic [4:0]  r_link     [NUM_BUFFERS];
    logic [4:0]  r_head     [NUM_BUCKETS];

    // Input word and working registers
    logic [1:0]  r_op;
    logic [7:0]  r_dev;
    logic [15:0] r_blk;
    logic [15:0] r_rem;
    logic [15:0] r_quo;
    logic        r_quo_ok;
    logic [4:0]  r_slot;
    logic [4:0]  r_cur, r_prev;
    logic [BkW-1:0] r_target, r_bk;
    logic [BkW:0]   r_bk_cnt;
    logic [StepW-1:0] r_steps;
    logic [4:0]  r_victim;
    logic [InitW-1:0] r_init;

    logic        cur_valid;
    logic [4:0]  cur_next;
    logic [4:0]  head_tgt;
    logic [4:0]  victim_next;
    logic        slot_ok;
    logic [7:0]  slot_cnt;
    logic [39:0] mod_prod;
    logic [15:0] quo_mul;

    assign cur_valid   = r_cur < 5'(NUM_BUFFERS);
    assign cur_next    = cur_valid ? r_link[r_cur] : hbbc_pkg::NullLink;
    assign head_tgt    = r_head[r_target];
    assign victim_next = (r_victim < 5'(NUM_BUFFERS)) ? r_link[r_victim] : hbbc_pkg::NullLink;
    assign slot_ok     = r_slot < 5'(NUM_BUFFERS);
    assign slot_cnt    = slot_ok ? r_count[r_slot] : 8'd0;

    // Bucket hash: quotient by reciprocal multiply, then one subtract
    assign mod_prod = {24'd0, r_rem} * {15'd0, ModMul};
    assign quo_mul  = r_quo * BkDiv;

    // Status to controller
    always_comb begin
        o_stat = '0;
        o_stat.init_done   = r_init == InitW'(NumInit);
        o_stat.mod_done    = r_rem < BkDiv;
        o_stat.is_get      = r_op == hbbc_pkg::OP_GET;
        o_stat.cur_null    = !cur_valid;
        o_stat.cur_match   = cur_valid && r_tag_dev[r_cur] == r_dev && r_tag_blk[r_cur] == r_blk;
        o_stat.cur_free    = cur_valid && r_count[r_cur] == 8'd0;
        o_stat.walk_over   = r_steps >= StepW'(NUM_BUFFERS);
        o_stat.scan_over   = r_bk_cnt >= (BkW+1)'(NUM_BUCKETS - 1);
        o_stat.same_bucket = r_bk == r_target;
        o_stat.unl_done    = (r_prev == hbbc_pkg::NullLink) || !(r_prev < 5'(NUM_BUFFERS))
                             || r_link[r_prev] == r_victim || r_steps >= StepW'(NUM_BUFFERS);
    end

    // Control registers and walk cursors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
        end else if (i_cmd.init_step && r_init != InitW'(NumInit)) begin
            r_init <= r_init + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_dev    <= i_device;
            r_blk    <= i_block_number;
            r_rem    <= i_block_number;
            r_quo_ok <= 1'b0;
            r_slot   <= i_buffer_slot;
        end
        // block mod buckets: latch quotient, then subtract its multiple
        if (i_cmd.mod_step) begin
            if (r_rem >= BkDiv) begin
                if (!r_quo_ok) begin
                    r_quo    <= mod_prod[39:24];
                    r_quo_ok <= 1'b1;
                end else begin
                    r_rem <= r_rem - quo_mul;
                end
            end else begin
                r_target <= BkW'(r_rem);
                r_bk     <= BkW'(r_rem);
                r_bk_cnt <= '0;
                r_cur    <= r_head[BkW'(r_rem)];
                r_steps  <= '0;
            end
        end
        if (i_cmd.hit_step || i_cmd.free_step) begin
            r_cur   <= cur_next;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.bk_load) begin
            r_cur   <= r_head[r_bk];
            r_steps <= '0;
        end
        if (i_cmd.bk_next) begin
            r_bk     <= (r_bk == BkLast) ? '0 : r_bk + 1'b1;
            r_bk_cnt <= r_bk_cnt + 1'b1;
        end
        if (i_cmd.unl_start) begin
            r_victim <= r_cur;
            r_prev   <= r_head[r_bk];
            r_steps  <= '0;
        end
        if (i_cmd.unl_step) begin
            if (!((r_prev == hbbc_pkg::NullLink) || !(r_prev < 5'(NUM_BUFFERS))
                  || r_link[r_prev] == r_victim)) begin
                r_prev  <= r_link[r_prev];
                r_steps <= r_steps + 1'b1;
            end
        end
    end

    // Buffer state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                r_tag_dev[i] <= '0;
                r_tag_blk[i] <= '0;
                r_count[i]   <= '0;
                r_cvalid[i]  <= 1'b0;
                r_link[i]    <= (i == 0) ? hbbc_pkg::NullLink : 5'(i - 1);
            end
            for (int b = 0; b < NUM_BUCKETS; b++)
                r_head[b] <= (b == 0) ? LastSlot : hbbc_pkg::NullLink;
        end else begin
            if (i_cmd.hit_apply) begin
                if (r_count[r_cur] != hbbc_pkg::CountMax) r_count[r_cur] <= r_count[r_cur] + 1'b1;
                r_cvalid[r_cur] <= 1'b1;
            end
            if (i_cmd.unl_step && r_head[r_bk] == r_victim) begin
                r_head[r_bk] <= victim_next;
            end else if (i_cmd.unl_step && r_prev < 5'(NUM_BUFFERS)
                         && r_link[r_prev] == r_victim) begin
                r_link[r_prev] <= victim_next;
            end
            if (i_cmd.claim) begin
                r_count[r_cur]   <= 8'd1;
                r_tag_dev[r_cur] <= r_dev;
                r_tag_blk[r_cur] <= r_blk;
                r_cvalid[r_cur]  <= 1'b1;
                if (r_bk != r_target) begin
                    r_link[r_cur]    <= head_tgt;
                    r_head[r_target] <= r_cur;
                end
            end
            if (i_cmd.count_apply && slot_ok) begin
                if (r_op == hbbc_pkg::OP_PIN) begin
                    if (slot_cnt != hbbc_pkg::CountMax) r_count[r_slot] <= slot_cnt + 1'b1;
                end else if (slot_cnt != 8'd0) begin
                    r_count[r_slot] <= slot_cnt - 1'b1;
                end
            end
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.hit_apply) begin
            o_granted_slot <= r_cur;
            o_was_hit      <= 1'b1;
            o_needs_read   <= !r_cvalid[r_cur];
            o_status       <= (r_count[r_cur] == hbbc_pkg::CountMax) ? hbbc_pkg::ST_OVERFLOW
                                                                     : hbbc_pkg::ST_OK;
        end
        if (i_cmd.claim) begin
            o_granted_slot <= r_cur;
            o_was_hit      <= 1'b0;
            o_needs_read   <= 1'b1;
            o_status       <= hbbc_pkg::ST_OK;
        end
        if (i_cmd.fail) begin
            o_granted_slot <= '0;
            o_was_hit      <= 1'b0;
            o_needs_read   <= 1'b0;
            o_status       <= hbbc_pkg::ST_NO_FREE;
        end
        if (i_cmd.count_apply) begin
            o_granted_slot <= r_slot;
            o_was_hit      <= 1'b0;
            o_needs_read   <= 1'b0;
            if (!slot_ok)                          o_status <= hbbc_pkg::ST_OK;
            else if (r_op == hbbc_pkg::OP_PIN)
                o_status <= (slot_cnt == hbbc_pkg::CountMax) ? hbbc_pkg::ST_OVERFLOW
                                                             : hbbc_pkg::ST_OK;
            else o_status <= (slot_cnt == 8'd0) ? hbbc_pkg::ST_UNDERFLOW : hbbc_pkg::ST_OK;
        end
    end

`ifndef SYNTHESIS
    a_claim_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.claim |-> cur_valid && r_count[r_cur] == 8'd0) else $error("claim of busy buffer");
    a_claim_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.claim |=> r_count[$past(r_cur)] == 8'd1) else $error("claim count");
    a_target_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.bk_load |-> r_bk <= BkLast) else $error("bucket out of range");
`endif
endmodule

// ===== rtl/hashed_block_buffer_cache_core.sv =====
// Flow (input word taken to result valid): release/pin/unpin pass S_MOD, S_COUNT, S_DONE;
// get walks the hit chain, and the hash adds a quotient latch and a subtract when
// block_number >= NUM_BUCKETS. A miss also scans buckets, walks their links and unlinks.
// One word in flight; the next is taken in the cycle after the result register loads, and
// the result register waits in S_DONE while the receiver stalls.
// Reset: synchronous active low; state restores at once, input ready after release once
// the S_RESET init sweep over NUM_BUFFERS+NUM_BUCKETS entries completes.
`timescale 1ns / 1ps
module hashed_block_buffer_cache_core #(
    parameter int NUM_BUFFERS = hbbc_pkg::NumBuffers,
    parameter int NUM_BUCKETS = hbbc_pkg::NumBuckets
) (
    input logic    i_clk,
    input logic    i_rst_n,
    hbbc_in_if.sink    in_ch,
    hbbc_out_if.source out_ch
);
    hbbc_pkg::t_cmd  cmd;
    hbbc_pkg::t_stat stat;
    logic out_set;
    logic r_out_valid;
    logic [4:0] res_slot;
    logic       res_hit;
    logic       res_rd;
    logic [1:0] res_status;
    logic [4:0] r_out_slot;
    logic       r_out_hit;
    logic       r_out_rd;
    logic [1:0] r_out_status;

    // Output valid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                          r_out_valid <= 1'b0;
        else if (out_set)                      r_out_valid <= 1'b1;
        else if (out_ch.ready)                 r_out_valid <= 1'b0;
    end
    assign out_ch.valid = r_out_valid;

    // Output word register, held while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (out_set) begin
            r_out_slot   <= res_slot;
            r_out_hit    <= res_hit;
            r_out_rd     <= res_rd;
            r_out_status <= res_status;
        end
    end
    assign out_ch.granted_slot = r_out_slot;
    assign out_ch.was_hit      = r_out_hit;
    assign out_ch.needs_read   = r_out_rd;
    assign out_ch.status       = r_out_status;

    hbbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .i_out_busy (r_out_valid && !out_ch.ready),
        .o_out_set  (out_set),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hbbc_dp #(.NUM_BUFFERS(NUM_BUFFERS), .NUM_BUCKETS(NUM_BUCKETS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_opcode       (in_ch.opcode),
        .i_device       (in_ch.device),
        .i_block_number (in_ch.block_number),
        .i_buffer_slot  (in_ch.buffer_slot),
        .o_granted_slot (res_slot),
        .o_was_hit      (res_hit),
        .o_needs_read   (res_rd),
        .o_status       (res_status)
    );
endmodule
